>>> rtl/tieq_pkg.sv
// ----------------------------------------------------------------------------
// tieq_pkg
// Shared types and codes for the timed interrupt event queue.
// ----------------------------------------------------------------------------
package tieq_pkg;

  localparam int unsigned MaxResults = 16;

  typedef enum logic [1:0] {
    OP_SCHED = 2'd0,
    OP_TICK  = 2'd1,
    OP_IDLE  = 2'd2,
    OP_DROP  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_HALT   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeSystem = 2'd1;
  localparam logic [7:0] CfgSystemStep = 8'd0;
  localparam logic [7:0] CfgUserStep   = 8'd1;
  localparam logic [2:0] SrcTimer = 3'd0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] delay;
    logic [2:0]  source_type;
    logic [31:0] event_arg;
    logic [1:0]  machine_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  fired_type;
    logic [31:0] fired_arg;
    logic [31:0] fired_time;
    logic [31:0] now_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] when;
    logic [2:0]  typ;
    logic [31:0] arg;
  } entry_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } cfg_item_t;

endpackage

>>> rtl/tieq_if.sv
// ----------------------------------------------------------------------------
// tieq_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tieq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/timed_interrupt_event_queue.sv
// Schedule: a rejected item (zero delay or full queue) gets its result in the cycle
// after acceptance; else each entry later than the new time moves toward the tail,
// then the new entry is written. Drop: removes the head, if any, and shifts the rest
// down. Tick/idle: head checks, with the queue shifted for each fired event; each fired
// result waits for the next head check. One item at a time: in_if.ready is low until its
// last result is taken. Reset (rst_ni low, async): empty queue, clock/counters zero, steps 10/1.
// ----------------------------------------------------------------------------
// timed_interrupt_event_queue
// Time-sorted event queue with a simulated clock, run by a small sequencer.
// ----------------------------------------------------------------------------
module timed_interrupt_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  tieq_if.sink   in_if,
  tieq_if.source out_if,
  tieq_if.sink   cfg_if
);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RW = $clog2(tieq_pkg::MaxResults + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN_RD = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_SHRD    = 7'b0001000,
    S_SHIFT   = 7'b0010000,
    S_RDHEAD  = 7'b0100000,
    S_CHECK   = 7'b1000000
  } state_e;

  function automatic tieq_pkg::out_item_t make_result(logic [1:0] kind,
                                                      tieq_pkg::entry_t ev,
                                                      logic [31:0] now, logic last);
    tieq_pkg::out_item_t r;
    r.kind       = kind;
    r.fired_type = ev.typ;
    r.fired_arg  = ev.arg;
    r.fired_time = ev.when;
    r.now_time   = now;
    r.last       = last;
    return r;
  endfunction

  state_e state_q, state_d;
  tieq_pkg::entry_t mem [QUEUE_DEPTH];
  tieq_pkg::entry_t rd_q;
  tieq_pkg::entry_t head_q, head_d;
  tieq_pkg::in_item_t item_q, item_d;
  logic [CW-1:0] count_q, count_d, pos_q, pos_d;
  logic [31:0] now_q, now_d, sys_ticks_q, sys_ticks_d, usr_ticks_q, usr_ticks_d;
  logic [31:0] idle_ticks_q, idle_ticks_d, when_q, when_d;
  logic [7:0] sys_step_q, usr_step_q;
  logic [RW-1:0] nres_q, nres_d;
  logic adv_q, adv_d, idle_mode_q, idle_mode_d, pend_q, pend_d;
  tieq_pkg::out_item_t out_q, out_d;
  logic out_v_q, out_v_d;

  // memory port controls
  logic we;
  logic [IW-1:0] wa, ra;
  tieq_pkg::entry_t wd, new_entry;

  assign in_if.ready  = (state_q == S_IDLE) && !out_v_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  logic in_acc, out_acc, slot_free;
  assign in_acc    = in_if.valid && in_if.ready;
  assign out_acc   = out_v_q && out_if.ready;
  assign slot_free = !out_v_q || out_acc;

  // shared comparator: read entry time against the clock or the new event time
  logic [31:0] cmp_ref;
  logic cmp_gt;
  assign cmp_ref = (state_q == S_CHECK) ? now_q : when_q;
  assign cmp_gt  = rd_q.when > cmp_ref;

  // head check terms, valid in S_CHECK
  logic advance_now, lone_timer, fire;
  logic [31:0] now_n;
  assign advance_now = adv_q && (count_q != '0) && cmp_gt;
  assign now_n       = advance_now ? rd_q.when : now_q;
  assign lone_timer  = idle_mode_q && (rd_q.typ == tieq_pkg::SrcTimer) &&
                       (count_q == CW'(1));
  assign fire        = (count_q != '0) && (!cmp_gt || adv_q) && !lone_timer &&
                       (nres_q < RW'(tieq_pkg::MaxResults));

  assign new_entry = '{when: when_q, typ: item_q.source_type, arg: item_q.event_arg};

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_step_q <= 8'd10;
      usr_step_q <= 8'd1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.data.index == tieq_pkg::CfgSystemStep) sys_step_q <= cfg_if.data.data;
      else if (cfg_if.data.index == tieq_pkg::CfgUserStep) usr_step_q <= cfg_if.data.data;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    now_d        = now_q;
    sys_ticks_d  = sys_ticks_q;
    usr_ticks_d  = usr_ticks_q;
    idle_ticks_d = idle_ticks_q;
    when_d       = when_q;
    item_d       = item_q;
    nres_d       = nres_q;
    adv_d        = adv_q;
    idle_mode_d  = idle_mode_q;
    pend_d       = pend_q;
    head_d       = head_q;
    out_d        = out_q;
    out_v_d      = out_v_q;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = '0;
    if (out_acc) out_v_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_if.data;
          nres_d = '0;
          pend_d = 1'b0;
          case (in_if.data.opcode)
            tieq_pkg::OP_SCHED: begin
              if (in_if.data.delay == 16'd0 || count_q == CW'(QUEUE_DEPTH)) begin
                out_d   = make_result(tieq_pkg::KIND_REJECT, '0, now_q, 1'b1);
                out_v_d = 1'b1;
              end else begin
                when_d  = now_q + 32'(in_if.data.delay);
                pos_d   = count_q;
                state_d = (count_q == '0) ? S_SCAN : S_SCAN_RD;
              end
            end
            tieq_pkg::OP_TICK: begin
              if (in_if.data.machine_mode == tieq_pkg::ModeSystem) begin
                now_d       = now_q + 32'(sys_step_q);
                sys_ticks_d = sys_ticks_q + 32'(sys_step_q);
              end else begin
                now_d       = now_q + 32'(usr_step_q);
                usr_ticks_d = usr_ticks_q + 32'(usr_step_q);
              end
              idle_mode_d = in_if.data.machine_mode == tieq_pkg::ModeIdle;
              adv_d       = 1'b0;
              state_d     = S_RDHEAD;
            end
            tieq_pkg::OP_IDLE: begin
              idle_mode_d = 1'b1;
              adv_d       = 1'b1;
              state_d     = S_RDHEAD;
            end
            default: begin
              if (count_q > CW'(1)) begin
                count_d = count_q - CW'(1);
                pos_d   = '0;
                state_d = S_SHRD;
              end else begin
                if (count_q != '0) count_d = count_q - CW'(1);
                out_d   = make_result(tieq_pkg::KIND_DONE, '0, now_q, 1'b1);
                out_v_d = 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        ra      = IW'(pos_q - CW'(1));
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // rd_q holds entry pos-1; move it up while it is later than the new time
        we = 1'b1;
        wa = IW'(pos_q);
        if (pos_q != '0 && cmp_gt) begin
          wd      = rd_q;
          pos_d   = pos_q - CW'(1);
          state_d = (pos_q == CW'(1)) ? S_SCAN : S_SCAN_RD;
        end else begin
          wd      = new_entry;
          count_d = count_q + CW'(1);
          out_d   = make_result(tieq_pkg::KIND_DONE, '0, now_q, 1'b1);
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SHRD: begin
        ra      = IW'(1);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        // move entry pos+1 down to pos, next read issued one entry ahead
        we = 1'b1;
        wa = IW'(pos_q);
        wd = rd_q;
        ra = IW'(pos_q + CW'(2));
        if (pos_q + CW'(1) == count_q) begin
          if (item_q.opcode == tieq_pkg::OP_DROP) begin
            out_d   = make_result(tieq_pkg::KIND_DONE, '0, now_q, 1'b1);
            out_v_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_RDHEAD;
          end
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      S_RDHEAD: begin
        ra      = '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // rd_q holds entry 0; the previous fired result is sent once its last flag is known
        ra = '0;
        if (fire) begin
          if (!pend_q || slot_free) begin
            if (pend_q) begin
              out_d   = make_result(tieq_pkg::KIND_FIRED, head_q, now_q, 1'b0);
              out_v_d = 1'b1;
            end
            if (advance_now) begin
              idle_ticks_d = idle_ticks_q + (rd_q.when - now_q);
              now_d        = rd_q.when;
            end
            adv_d   = 1'b0;
            head_d  = rd_q;
            pend_d  = 1'b1;
            nres_d  = nres_q + RW'(1);
            count_d = count_q - CW'(1);
            pos_d   = '0;
            state_d = (count_q == CW'(1)) ? S_RDHEAD : S_SHRD;
          end
        end else if (slot_free) begin
          if (advance_now) begin
            idle_ticks_d = idle_ticks_q + (rd_q.when - now_q);
            now_d        = rd_q.when;
          end
          adv_d = 1'b0;
          if (pend_q) out_d = make_result(tieq_pkg::KIND_FIRED, head_q, now_n, 1'b1);
          else if (item_q.opcode == tieq_pkg::OP_TICK)
            out_d = make_result(tieq_pkg::KIND_DONE, '0, now_n, 1'b1);
          else out_d = make_result(tieq_pkg::KIND_HALT, '0, now_n, 1'b1);
          out_v_d = 1'b1;
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pos_q        <= '0;
      now_q        <= '0;
      sys_ticks_q  <= '0;
      usr_ticks_q  <= '0;
      idle_ticks_q <= '0;
      when_q       <= '0;
      item_q       <= '0;
      nres_q       <= '0;
      adv_q        <= 1'b0;
      idle_mode_q  <= 1'b0;
      pend_q       <= 1'b0;
      head_q       <= '0;
      out_q        <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      now_q        <= now_d;
      sys_ticks_q  <= sys_ticks_d;
      usr_ticks_q  <= usr_ticks_d;
      idle_ticks_q <= idle_ticks_d;
      when_q       <= when_d;
      item_q       <= item_d;
      nres_q       <= nres_d;
      adv_q        <= adv_d;
      idle_mode_q  <= idle_mode_d;
      pend_q       <= pend_d;
      head_q       <= head_d;
      out_q        <= out_d;
      out_v_q      <= out_v_d;
    end
  end
endmodule

>>> rtl/tieq_checker.sv
// ----------------------------------------------------------------------------
// tieq_checker
// Port-level checks for the event queue.
// ----------------------------------------------------------------------------
module tieq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [31:0] out_fired_time_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != tieq_pkg::KIND_FIRED |-> out_fired_time_i == 32'd0)
    else $error("nonzero fired time");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready while busy");
endmodule

bind timed_interrupt_event_queue tieq_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_kind_i(out_if.data.kind), .out_fired_time_i(out_if.data.fired_time)
);
